[rtl/core/ilie_pkg.sv]
// shared types and constants for the indexed list block
package ilie_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 9;
  localparam int CNT_W  = 9;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SIZE   = 3'd4;

  localparam logic [STAT_W-1:0] STS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STS_REJECT   = 2'd1;
  localparam logic [STAT_W-1:0] STS_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STS_PAST_END = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_COMMIT,
    S_DONE
  } ilie_state_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic shift;
    logic commit;
    logic load_out;
  } ilie_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic shift_done;
  } ilie_sts_t;

endpackage

[rtl/core/ilie_ifs.sv]
// command and result channel interfaces
interface ilie_in_if import ilie_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic [CNT_W-1:0]        count;
  logic                    last_element;

  modport source(output valid, input ready, output opcode, output position,
                 output value, output count, output last_element);
  modport sink(input valid, output ready, input opcode, input position,
               input value, input count, input last_element);
endinterface

interface ilie_out_if import ilie_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        length;

  modport source(output valid, input ready, output status, output read_value,
                 output length);
  modport sink(input valid, output ready, input status, input read_value,
               input length);
endinterface

[rtl/core/ilie_ctrl.sv]
// sequencing state machine for the indexed list
module ilie_ctrl import ilie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ilie_sts_t sts,
  output ilie_cmd_t cmd
);

  ilie_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = sts.need_shift ? S_SHIFT : S_COMMIT;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DECODE: cmd.decode = 1'b1;
      S_SHIFT:  cmd.shift  = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_DONE:   cmd.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/ilie_datapath.sv]
// entry memory, length and run registers, shift engine and result register
module ilie_datapath import ilie_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ilie_cmd_t                cmd,
  output ilie_sts_t                sts,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [CNT_W-1:0]         in_count,
  input  logic                     in_last_element,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [LEN_W-1:0]         out_length
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (LW > POS_W) ? LW : POS_W;
  localparam int DW = DATA_WIDTH;

  logic [DW-1:0] entries_r [CAPACITY];
  logic [DW-1:0] rdata_r;

  // latched command word
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [DW-1:0]    val_r;
  logic [CNT_W-1:0] cnt_r;
  logic             last_r;

  // list state
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cursor_r, cursor_nxt;
  logic          run_active_r, run_active_nxt;
  logic          run_accepted_r, run_accepted_nxt;

  // decoded plan
  logic [STAT_W-1:0] status_r;
  logic [LW-1:0]     mv_r, mv_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic              up_r;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              do_ins_r, do_set_r, do_get_r;
  logic [LW-1:0]     sub_r;

  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_rd_r;
  logic [LEN_W-1:0]  out_len_r;

  logic [VAL_W+63:0] val_ext;
  logic [DW+63:0]    rd_ext;

  logic [CW-1:0] pos_w, len_w, cnt_w, cur_w, room, ers_n, ins_cur;
  logic          start, ins_acc, in_range;

  logic [STAT_W-1:0] dec_status;
  logic [LW-1:0]     dec_mv, dec_sub;
  logic [AW-1:0]     dec_src, dec_dst;
  logic              dec_up, dec_ins, dec_set, dec_get;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;

  assign val_ext = {{64{in_value[VAL_W-1]}}, in_value};
  assign rd_ext  = {{64{rdata_r[DW-1]}}, rdata_r};

  always_comb begin
    pos_w    = CW'(pos_r);
    len_w    = CW'(len_r);
    cnt_w    = CW'(cnt_r);
    cur_w    = CW'(cursor_r);
    start    = !run_active_r;
    ins_acc  = start ? (pos_w <= len_w) : run_accepted_r;
    ins_cur  = start ? pos_w : cur_w;
    in_range = pos_w < len_w;
    room     = len_w - pos_w;
    ers_n    = (cnt_w < room) ? cnt_w : room;

    dec_status = STS_OK;
    dec_mv     = '0;
    dec_sub    = '0;
    dec_src    = '0;
    dec_dst    = '0;
    dec_up     = 1'b0;
    dec_ins    = 1'b0;
    dec_set    = 1'b0;
    dec_get    = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (!ins_acc) begin
          dec_status = STS_REJECT;
        end else if (len_w >= CW'(CAPACITY) || ins_cur > len_w) begin
          dec_status = STS_FULL;
        end else begin
          // move the tail up one place, top entry first
          dec_ins = 1'b1;
          dec_mv  = LW'(len_w - ins_cur);
          dec_src = AW'(len_w - CW'(1));
          dec_dst = AW'(len_w);
        end
      end
      OP_ERASE: begin
        if (in_range && cnt_r != '0) begin
          // pull the tail down over the erased gap, bottom entry first
          dec_sub = LW'(ers_n);
          dec_mv  = LW'(room - ers_n);
          dec_src = AW'(pos_w + ers_n);
          dec_dst = AW'(pos_w);
          dec_up  = 1'b1;
        end
      end
      OP_GET: begin
        if (in_range) dec_get = 1'b1;
        else dec_status = STS_PAST_END;
      end
      OP_SET: begin
        if (in_range) dec_set = 1'b1;
        else dec_status = STS_PAST_END;
      end
      default: ;
    endcase
  end

  assign sts.need_shift = dec_mv != '0;
  assign sts.shift_done = (mv_r == '0) && !pend_r;

  // run tracking and length
  always_comb begin
    run_active_nxt   = run_active_r;
    run_accepted_nxt = run_accepted_r;
    cursor_nxt       = cursor_r;
    len_nxt          = len_r;
    if (cmd.decode) begin
      if (op_r == OP_INSERT) begin
        run_active_nxt = !last_r;
        if (start) begin
          run_accepted_nxt = pos_w <= len_w;
          cursor_nxt       = LW'(pos_w);
        end
      end else begin
        run_active_nxt = 1'b0;
      end
    end
    if (cmd.commit) begin
      if (do_ins_r) cursor_nxt = cursor_r + LW'(1);
      len_nxt = len_r + LW'(do_ins_r) - sub_r;
    end
  end

  // memory port steering
  always_comb begin
    mv_nxt      = mv_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    pend_nxt    = pend_r;
    wr_addr_nxt = wr_addr_r;
    rd_en       = 1'b0;
    rd_addr     = src_r;
    wr_en       = 1'b0;
    wr_addr     = wr_addr_r;
    wr_data     = rdata_r;
    if (cmd.decode) begin
      mv_nxt   = dec_mv;
      src_nxt  = dec_src;
      dst_nxt  = dec_dst;
      pend_nxt = 1'b0;
    end
    if (cmd.shift) begin
      if (mv_r != '0) begin
        rd_en       = 1'b1;
        mv_nxt      = mv_r - LW'(1);
        src_nxt     = up_r ? src_r + AW'(1) : src_r - AW'(1);
        dst_nxt     = up_r ? dst_r + AW'(1) : dst_r - AW'(1);
        pend_nxt    = 1'b1;
        wr_addr_nxt = dst_r;
      end else begin
        pend_nxt = 1'b0;
      end
      // word read last cycle lands at its new place
      if (pend_r) wr_en = 1'b1;
    end
    if (cmd.commit) begin
      if (do_ins_r) begin
        wr_en   = 1'b1;
        wr_addr = AW'(cursor_r);
        wr_data = val_r;
      end else if (do_set_r) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_r);
        wr_data = val_r;
      end
      if (do_get_r) begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= entries_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      pos_r  <= in_position;
      val_r  <= val_ext[DW-1:0];
      cnt_r  <= in_count;
      last_r <= in_last_element;
    end
    if (cmd.decode) begin
      status_r <= dec_status;
      up_r     <= dec_up;
      sub_r    <= dec_sub;
    end
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    wr_addr_r <= wr_addr_nxt;
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_rd_r     <= do_get_r ? rd_ext[VAL_W-1:0] : '0;
      out_len_r    <= LEN_W'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r          <= '0;
      cursor_r       <= '0;
      run_active_r   <= 1'b0;
      run_accepted_r <= 1'b0;
      mv_r           <= '0;
      pend_r         <= 1'b0;
      do_ins_r       <= 1'b0;
      do_set_r       <= 1'b0;
      do_get_r       <= 1'b0;
    end else begin
      len_r          <= len_nxt;
      cursor_r       <= cursor_nxt;
      run_active_r   <= run_active_nxt;
      run_accepted_r <= run_accepted_nxt;
      mv_r           <= mv_nxt;
      pend_r         <= pend_nxt;
      if (cmd.decode) begin
        do_ins_r <= dec_ins;
        do_set_r <= dec_set;
        do_get_r <= dec_get;
      end
    end
  end

  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;
  assign out_length     = out_len_r;

endmodule

[rtl/core/indexed_list_insert_erase.sv]
// top level of the indexed list: insert, erase, get, set and size by position
//
// in_ch carries one command word per valid/ready handshake; out_ch returns
// exactly one result word per command (status, read_value, length after it).
// Commands run one at a time. A command that moves no entries (get, set,
// size, a rejected or full insert, an erase that removes the tail or
// nothing) passes from accept through the decode, commit and done states
// to its result in the output register, and the next command is taken only
// once the block is back in idle. An insert or erase that moves entries
// also passes through the shift state: the entry memory has one write port,
// so the shift engine relocates one entry per cycle, each entry read into a
// register in the cycle before it is written.
// The output register parts the two sides: a new command is taken while a
// result still waits; if the receiver stalls, the next result is held in
// its final state until the output register frees up.
// Reset clears the length, insert cursor and run state and empties the
// output register; stored entries are left as they are, since only
// positions below the length are ever read.
module indexed_list_insert_erase import ilie_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  ilie_in_if.sink    in_ch,
  ilie_out_if.source out_ch
);

  ilie_cmd_t cmd;
  ilie_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  ilie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ilie_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .in_count        (in_ch.count),
    .in_last_element (in_ch.last_element),
    .out_status      (out_ch.status),
    .out_read_value  (out_ch.read_value),
    .out_length      (out_ch.length)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

[rtl/core/ilie_checker.sv]
// port-level checks for the indexed list, bound to the top level
module ilie_checker import ilie_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STAT_W-1:0]       out_status,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [LEN_W-1:0]        out_length
);

  localparam logic [LEN_W-1:0] CAP_MOD = LEN_W'(CAPACITY);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_length))
    else $error("result word changed while stalled");

  // one command at a time: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous still in work");

  // a failed command returns zero read data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_read_value == '0)
    else $error("read data on a failed command");

  // store full only reported at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_FULL |-> out_length == CAP_MOD)
    else $error("store full reported below capacity");

  // length never exceeds capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY >= 512) || (int'(out_length) <= CAPACITY))
    else $error("length above capacity");

endmodule

bind indexed_list_insert_erase ilie_checker #(
  .CAPACITY (CAPACITY)
) u_ilie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_read_value (out_ch.read_value),
  .out_length     (out_ch.length)
);
